// ===== sv/assert_macros.svh =====
// Assertion macros shared by the gesture block's RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define BGPH_ASSERT(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bgph_pkg.sv =====
// Types and constants for the button gesture / supply hold block.
// No dependencies; imported by every module of the block.
package bgph_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned PRESS_SECS_W = 5;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [7:0] SECONDS_CAP = 8'd25;
	localparam logic [7:0] RESET_COUNTDOWN = 8'd100;
	localparam logic [7:0] MIN_HOLD_RESET = 8'd10;
	localparam logic [7:0] DBL_WINDOW_RESET = 8'd6;
	localparam logic [PRESS_SECS_W-1:0] PRESS_SECS_RESET = 5'd10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SECS = 2'd2;

	// item kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_HOLD_REQ = 1'b1;

	typedef struct packed {
		logic press;
		logic hold;
		logic release_ev;
		logic dbl_click;
		logic hold_release;
	} bgph_events_t;

	// min(s, 25) * 10 as a shift-add; max 250 fits 8 bits
	function automatic logic [7:0] bgph_secs_to_ticks(input logic [7:0] secs);
		logic [4:0] s;
		s = (secs > SECONDS_CAP) ? SECONDS_CAP[4:0] : secs[4:0];
		return {s, 3'b000} + {2'b00, s, 1'b0};
	endfunction

endpackage

// ===== sv/button_gesture_power_hold_top.sv =====
// Top level of the button gesture detector with auto-off supply hold.
// Depends on bgph_pkg, bgph_gesture, bgph_timer and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per item. mode 0 is a
//   100 ms tick carrying button_level (0 = pressed) and usb_present; mode 1
//   is a hold request setting the auto-off delay to min(hold_seconds,25) s
//   when USB is absent.
//   Output channel (out_valid / out_stall): one result per request, with the
//   five event pulses (all 0 for hold requests), supply_enable and the
//   remaining ticks_to_off.
//   out_valid rises when a request moves from the input register into the
//   result register. Throughput: one request per cycle while out_stall is low,
//   set by the input register feeding the gesture and timer logic, which
//   updates state and loads the result register at once. A stalled result
//   holds; the input register then fills and in_stall rises, so nothing is
//   dropped. Config (cfg_write / cfg_index / cfg_data) is to be written by
//   the user only while idle; the block does not enforce this. Reset:
//   released phase, countdown 100 ticks, supply on, registers at 10 / 6 / 10.
module button_gesture_power_hold_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bgph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bgph_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic                                button_level,
	input  logic                                usb_present,
	input  logic [7:0]                          hold_seconds,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                press_event,
	output logic                                hold_event,
	output logic                                release_event,
	output logic                                double_click_event,
	output logic                                hold_release_event,
	output logic                                supply_enable,
	output logic [7:0]                          ticks_to_off
);
	import bgph_pkg::*;

	logic [7:0]              min_hold_q;
	logic [7:0]              dbl_window_q;
	logic [PRESS_SECS_W-1:0] press_secs_q;

	logic       valid_s1;
	logic       mode_s1, level_s1, usb_s1;
	logic [7:0] secs_s1;

	logic       advance, accept_in, tick_s1, step_tick;
	logic       tm_load;
	logic [7:0] tm_secs, count_next;
	logic       supply_next;

	bgph_events_t events;
	bgph_events_t events_q;
	logic         supply_q;
	logic [7:0]   ticks_q;
	logic         out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hold_q <= MIN_HOLD_RESET;
			dbl_window_q <= DBL_WINDOW_RESET;
			press_secs_q <= PRESS_SECS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MIN_HOLD:   min_hold_q <= cfg_data;
				CFG_DBL_WINDOW: dbl_window_q <= cfg_data;
				CFG_PRESS_SECS: press_secs_q <= cfg_data[PRESS_SECS_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_s1 <= mode;
			level_s1 <= button_level;
			usb_s1 <= usb_present;
			secs_s1 <= hold_seconds;
		end
	end

	assign tick_s1 = (mode_s1 == MODE_TICK);
	assign step_tick = advance && tick_s1;

	bgph_gesture u_gesture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step_tick),
		.pressed    (!level_s1),
		.min_hold   (min_hold_q),
		.dbl_window (dbl_window_q),
		.events     (events)
	);

	// a confirmed press reloads with the press extension, a hold request with its own
	assign tm_load = tick_s1 ? events.press : (mode_s1 == MODE_HOLD_REQ);
	assign tm_secs = tick_s1 ? {{(8-PRESS_SECS_W){1'b0}}, press_secs_q} : secs_s1;

	bgph_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.tick        (tick_s1),
		.usb         (usb_s1),
		.load        (tm_load),
		.load_secs   (tm_secs),
		.count_next  (count_next),
		.supply_next (supply_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			events_q <= tick_s1 ? events : '0;
			supply_q <= supply_next;
			ticks_q <= count_next;
		end
	end

	assign out_valid = out_valid_q;
	assign press_event = events_q.press;
	assign hold_event = events_q.hold;
	assign release_event = events_q.release_ev;
	assign double_click_event = events_q.dbl_click;
	assign hold_release_event = events_q.hold_release;
	assign supply_enable = supply_q;
	assign ticks_to_off = ticks_q;

	`include "assert_macros.svh"

	// a request that could not move on must still be held next cycle
	`BGPH_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1,
		"request lost from input register")

endmodule

// ===== sv/bgph_gesture.sv =====
// Debounce and gesture state machine: press, hold, release, hold release, double click.
// Depends on bgph_pkg and assert_macros.svh.
module bgph_gesture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                pressed,
	input  logic [7:0]          min_hold,
	input  logic [7:0]          dbl_window,
	output bgph_pkg::bgph_events_t events
);
	import bgph_pkg::*;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_BOUNCING = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [7:0]   held_q, held_d, held_inc;
	logic [7:0]   win_q, win_d;
	bgph_events_t ev;

	assign held_inc = held_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		held_d = held_q;
		win_d = win_q;
		ev = '0;
		case (phase_q)
			PH_RELEASED: begin
				if (win_q != 8'd0)
					win_d = win_q - 8'd1;
				if (pressed)
					phase_d = PH_BOUNCING;
			end
			PH_BOUNCING: begin
				if (pressed) begin
					ev.press = 1'b1;
					held_d = 8'd1;
					phase_d = PH_PRESSED;
				end else begin
					phase_d = PH_RELEASED;
				end
			end
			PH_PRESSED: begin
				held_d = held_inc;
				// hold period wins over a release on the same tick
				if (held_inc >= min_hold) begin
					ev.hold = 1'b1;
					held_d = 8'd0;
					phase_d = PH_LONG;
				end else if (!pressed) begin
					if (win_q != 8'd0) begin
						ev.dbl_click = 1'b1;
						win_d = 8'd0;
					end else begin
						win_d = dbl_window;
					end
					ev.release_ev = 1'b1;
					phase_d = PH_RELEASED;
				end
			end
			PH_LONG: begin
				held_d = held_inc;
				if (held_inc >= min_hold) begin
					ev.hold = 1'b1;
					held_d = 8'd0;
				end else if (!pressed) begin
					ev.hold_release = 1'b1;
					phase_d = PH_RELEASED;
				end
			end
			default: begin
				phase_d = PH_RELEASED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASED;
			held_q <= 8'd0;
			win_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			held_q <= held_d;
			win_q <= win_d;
		end
	end

	assign events = ev;

	`include "assert_macros.svh"

	// at most one gesture pulse per tick, except double click rides on release
	`BGPH_ASSERT(a_ev_excl, clk, arst_n,
		$onehot0({ev.press, ev.hold, ev.release_ev, ev.hold_release}), "gesture events overlap")
	`BGPH_ASSERT(a_dbl_with_rel, clk, arst_n,
		!ev.dbl_click || ev.release_ev, "double click without release")

endmodule

// ===== sv/bgph_timer.sv =====
// Auto-off countdown and latched supply enable.
// Depends on bgph_pkg and assert_macros.svh.
module bgph_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       tick,
	input  logic       usb,
	input  logic       load,
	input  logic [7:0] load_secs,
	output logic [7:0] count_next,
	output logic       supply_next
);
	import bgph_pkg::*;

	logic [7:0] count_q;
	logic       supply_q;
	logic [7:0] loaded;

	// reload is skipped while USB is present
	assign loaded = (load && !usb) ? bgph_secs_to_ticks(load_secs) : count_q;

	always_comb begin
		count_next = loaded;
		supply_next = supply_q;
		if (tick) begin
			if (loaded != 8'd0)
				count_next = loaded - 8'd1;
			else
				supply_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_COUNTDOWN;
			supply_q <= 1'b1;
		end else if (step) begin
			count_q <= count_next;
			supply_q <= supply_next;
		end
	end

	`include "assert_macros.svh"

	`BGPH_ASSERT_NEXT(a_supply_latched, clk, arst_n, !supply_q, !supply_q,
		"supply enable came back on")
	`BGPH_ASSERT(a_count_range, clk, arst_n, count_q <= 8'd250, "countdown out of range")

endmodule
